// ===== src/lceg_pkg.sv =====
`default_nettype none

package lceg_pkg;

  // Event mode codes held in the mode register.
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_AND = 2'd1;
  localparam logic [1:0] MODE_OR  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_EVENT_MODE     = 2'd0;
  localparam logic [1:0] REG_READ_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_DIFF_THRESHOLD = 2'd2;

  localparam int unsigned TimeBits   = 32;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = 32;

  // Decision flags from the evaluation logic to the top level.
  typedef struct packed {
    logic active;      // mode is not off, so state may change
    logic load_level;  // saved level takes the sample
    logic fire;        // an event beat is produced
    logic darkened;    // sample above the effective saved level
  } lceg_dec_t;

endpackage

`default_nettype wire

// ===== src/lceg_eval.sv =====
`default_nettype none

module lceg_eval #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic [1:0]                    mode_i,
  input  wire logic [lceg_pkg::TimeBits-1:0] interval_i,
  input  wire logic [SAMPLE_BITS-1:0]        threshold_i,
  input  wire logic [lceg_pkg::TimeBits-1:0] now_i,
  input  wire logic [SAMPLE_BITS-1:0]        sample_i,
  input  wire logic [SAMPLE_BITS-1:0]        saved_level_i,
  input  wire logic [lceg_pkg::TimeBits-1:0] saved_time_i,
  output lceg_pkg::lceg_dec_t                dec_o
);
  import lceg_pkg::*;

  logic [SAMPLE_BITS-1:0] ref_level;
  logic [SAMPLE_BITS-1:0] diff;
  logic [TimeBits-1:0]    elapsed;
  logic                   level_unset;
  logic                   time_ok;
  logic                   change_ok;
  logic                   fire;

  // An unset saved level is replaced by the current sample before the change test.
  assign level_unset = (saved_level_i == '0);
  assign ref_level   = level_unset ? sample_i : saved_level_i;

  // Elapsed time wraps modulo 2^32; a zero interval is always met.
  assign elapsed = now_i - saved_time_i;
  assign time_ok = (interval_i == '0) || (elapsed >= interval_i);

  // Absolute light change against the effective saved level.
  assign diff      = (sample_i >= ref_level) ? (sample_i - ref_level) : (ref_level - sample_i);
  assign change_ok = (threshold_i == '0) || (diff >= threshold_i);

  // Combine the two conditions according to the mode; other codes never fire.
  always_comb begin
    case (mode_i)
      MODE_AND: fire = time_ok && change_ok;
      MODE_OR:  fire = time_ok || change_ok;
      default:  fire = 1'b0;
    endcase
  end

  assign dec_o.active     = (mode_i != MODE_OFF);
  assign dec_o.fire       = fire;
  assign dec_o.load_level = (mode_i != MODE_OFF) && (level_unset || fire);
  assign dec_o.darkened   = (sample_i > ref_level);

endmodule

`default_nettype wire

// ===== src/light_change_event_gate.sv =====
`default_nettype none

// Light change event gate.
// The sample channel (sample_valid_i / sample_ready_o) carries one beat per light
// reading: a millisecond time stamp and a converter value. The event channel
// (event_valid_o / event_ready_i) carries one beat per reported change: the
// level and a darkened flag. A sample produces zero or one event beat.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i). The
// user must change it only while idle; the block itself does not enforce this.
// A sample beat lands in an input register; when the held sample advances, the
// gate decision, the saved-state update and the event register load all happen
// together. One sample beat is accepted every cycle while the event receiver
// keeps up; the single subtract-and-compare pass between the input and event
// registers sets this. When the receiver stalls with an event beat pending, an
// empty input register still takes one beat; a held sample stays there and the
// sample channel deasserts ready.
// Reset clears the configuration, the saved level (unset) and the saved time,
// and empties both registers.
module light_change_event_gate #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lceg_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  wire logic [lceg_pkg::CfgBits-1:0]      cfg_data_i,
  input  wire logic                              sample_valid_i,
  output logic                                   sample_ready_o,
  input  wire logic [lceg_pkg::TimeBits-1:0]     now_ms_i,
  input  wire logic [SAMPLE_BITS-1:0]            luminosity_i,
  output logic                                   event_valid_o,
  input  wire logic                              event_ready_i,
  output logic [SAMPLE_BITS-1:0]                 level_o,
  output logic                                   darkened_o
);
  import lceg_pkg::*;

  logic [1:0]             mode_q;
  logic [TimeBits-1:0]    interval_q;
  logic [SAMPLE_BITS-1:0] threshold_q;

  logic                   in_valid_q;
  logic [TimeBits-1:0]    now_q;
  logic [SAMPLE_BITS-1:0] sample_q;

  logic [SAMPLE_BITS-1:0] saved_level_q;
  logic [TimeBits-1:0]    saved_time_q;

  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] level_q;
  logic                   darkened_q;

  logic                   advance;
  logic                   sample_take;
  lceg_dec_t              dec;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OFF;
      interval_q  <= '0;
      threshold_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_EVENT_MODE:     mode_q      <= cfg_data_i[1:0];
        REG_READ_INTERVAL:  interval_q  <= cfg_data_i[TimeBits-1:0];
        REG_DIFF_THRESHOLD: threshold_q <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The held sample moves on when the event register is free or being drained.
  assign advance        = in_valid_q && (!out_valid_q || event_ready_i);
  assign sample_ready_o = !in_valid_q || advance;
  assign sample_take    = sample_valid_i && sample_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_ready_o) begin
      in_valid_q <= sample_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_take) begin
      now_q    <= now_ms_i;
      sample_q <= luminosity_i;
    end
  end

  lceg_eval #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_eval (
    .mode_i        (mode_q),
    .interval_i    (interval_q),
    .threshold_i   (threshold_q),
    .now_i         (now_q),
    .sample_i      (sample_q),
    .saved_level_i (saved_level_q),
    .saved_time_i  (saved_time_q),
    .dec_o         (dec)
  );

  // Saved level and time of the last reported event; an unset level takes any sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_level_q <= '0;
      saved_time_q  <= '0;
    end else if (advance) begin
      if (dec.load_level) begin
        saved_level_q <= sample_q;
      end
      if (dec.fire) begin
        saved_time_q <= (interval_q == '0) ? '0 : now_q;
      end
    end
  end

  // Event register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= dec.fire;
    end else if (event_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && dec.fire) begin
      level_q    <= sample_q;
      darkened_q <= dec.darkened;
    end
  end

  assign event_valid_o = out_valid_q;
  assign level_o       = level_q;
  assign darkened_o    = darkened_q;

  // A reported event leaves its level as the saved level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && dec.fire |=> saved_level_q == level_q && out_valid_q)
    else $error("saved level differs from the reported event level");

  // With the mode off, a sample leaves the saved state untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !dec.active |=> $stable(saved_level_q) && $stable(saved_time_q))
    else $error("saved state changed while events are disabled");

  // A zero interval stores a zero time on every event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && dec.fire && interval_q == '0 |=> saved_time_q == '0)
    else $error("saved time not cleared with a zero interval");

  // The sample channel only stalls behind a held sample and a stalled event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_ready_o |-> in_valid_q && out_valid_q && !event_ready_i)
    else $error("sample channel stalled without cause");

endmodule

`default_nettype wire
